### hdl/terminal_line_editor_unit_macros.svh
// ============================================================================
// Terminal line editor assertion macros
// Shared assertion forms used by the line editor RTL.
// ============================================================================
`ifndef TERMINAL_LINE_EDITOR_UNIT_MACROS_SVH
`define TERMINAL_LINE_EDITOR_UNIT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define TLE_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define TLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/tle_pkg.sv
// ============================================================================
// Terminal line editor package
// Capacity, key codes, escape phases and result kinds.
// ============================================================================
`default_nettype none
package tle_pkg;
  localparam int LINE_CAPACITY = 64;
  localparam int ADDR_W        = $clog2(LINE_CAPACITY);
  localparam int PTR_W         = $clog2(LINE_CAPACITY + 1);

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [7:0]        byte_t;

  localparam byte_t KEY_CTRL_A = 8'd1;
  localparam byte_t KEY_CTRL_C = 8'd3;
  localparam byte_t KEY_CTRL_D = 8'd4;
  localparam byte_t KEY_CTRL_E = 8'd5;
  localparam byte_t KEY_BS     = 8'd8;
  localparam byte_t KEY_LF     = 8'd10;
  localparam byte_t KEY_CTRL_K = 8'd11;
  localparam byte_t KEY_CR     = 8'd13;
  localparam byte_t KEY_CTRL_U = 8'd21;
  localparam byte_t KEY_CTRL_W = 8'd23;
  localparam byte_t KEY_ESC    = 8'd27;
  localparam byte_t KEY_SPACE  = 8'd32;
  localparam byte_t KEY_TILDE  = 8'd126;
  localparam byte_t KEY_DEL    = 8'd127;

  typedef logic [2:0] phase_t;
  localparam phase_t PH_IDLE  = 3'd0;
  localparam phase_t PH_ESC   = 3'd1;
  localparam phase_t PH_CSI   = 3'd2;
  localparam phase_t PH_SS3   = 3'd3;
  localparam phase_t PH_DIGIT = 3'd4;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_STATUS = 2'd0;
  localparam kind_t KIND_BYTE   = 2'd1;
  localparam kind_t KIND_EMPTY  = 2'd2;
  localparam kind_t KIND_END    = 2'd3;
endpackage
`default_nettype wire

### hdl/terminal_line_editor_unit.sv
// ============================================================================
// Terminal line editor
// Keystroke-driven line buffer with cursor, escape decoding and line output.
// ============================================================================
// One keystroke request is taken at a time; in_tready is high only while the
// sequencer is idle. Every edit that moves stored bytes (insert, delete,
// backspace, Ctrl-U, Ctrl-W) runs through a copy engine on the 64-byte line
// memory one byte at a time, because each byte needs a registered read
// followed by a write. Ctrl-W first scans backwards one byte at a time.
// Enter or end of input on a non-empty line reads the line out byte by byte,
// each a registered read and then a load of the output register, which waits
// while the result side stalls. Results leave through an output register, so
// one finished result can wait while the sequencer carries on.
`default_nettype none
`include "terminal_line_editor_unit_macros.svh"
module terminal_line_editor_unit
  import tle_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] key
  input  wire logic        in_tuser,   // [0] end_of_input
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [7:0] char_out, [14:8] cursor,
                                       // [21:15] length, [22] overflow, [23] 0
  output logic [1:0]       out_tuser,  // [1:0] kind
  output logic             out_tlast   // last result of this request
);

  // Sequencer state codes.
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_CP_RD  = 4'd1;
  localparam logic [3:0] ST_CP_WR  = 4'd2;
  localparam logic [3:0] ST_INS    = 4'd3;
  localparam logic [3:0] ST_W1_RD  = 4'd4;
  localparam logic [3:0] ST_W1_CHK = 4'd5;
  localparam logic [3:0] ST_W2_RD  = 4'd6;
  localparam logic [3:0] ST_W2_CHK = 4'd7;
  localparam logic [3:0] ST_SD_RD  = 4'd8;
  localparam logic [3:0] ST_SD_LD  = 4'd9;
  localparam logic [3:0] ST_STAT   = 4'd10;

  localparam ptr_t CAP = ptr_t'(LINE_CAPACITY);

  logic [3:0] state_r, state_nxt;
  ptr_t       len_r, len_nxt, cur_r, cur_nxt;
  phase_t     ph_r, ph_nxt;
  byte_t      dig_r, dig_nxt;
  ptr_t       src_r, src_nxt, dst_r, dst_nxt, cnt_r, cnt_nxt, old_r, old_nxt;
  logic       back_r, back_nxt, ins_r, ins_nxt, ovf_r, ovf_nxt;
  kind_t      skind_r, skind_nxt;
  byte_t      key_r, key_nxt;

  // Line memory: one write port, one registered read port.
  byte_t      mem [LINE_CAPACITY];
  byte_t      rdata_r;
  logic       we;
  addr_t      waddr;
  byte_t      wdata;

  // Output register.
  logic       out_valid_r;
  byte_t      o_char_r;
  ptr_t       o_cur_r, o_len_r;
  logic       o_ovf_r, o_last_r;
  kind_t      o_kind_r;
  logic       ld;
  kind_t      ld_kind;
  byte_t      ld_char;
  logic       ld_ovf, ld_last;
  logic       out_free;

  logic       accept;
  byte_t      c;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign c         = in_tdata;
  assign out_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[src_r[ADDR_W-1:0]];
  end

  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    cur_nxt   = cur_r;
    ph_nxt    = ph_r;
    dig_nxt   = dig_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    cnt_nxt   = cnt_r;
    old_nxt   = old_r;
    back_nxt  = back_r;
    ins_nxt   = ins_r;
    ovf_nxt   = ovf_r;
    skind_nxt = skind_r;
    key_nxt   = key_r;
    we        = 1'b0;
    waddr     = dst_r[ADDR_W-1:0];
    wdata     = rdata_r;
    ld        = 1'b0;
    ld_kind   = skind_r;
    ld_char   = '0;
    ld_ovf    = ovf_r;
    ld_last   = 1'b1;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          // By default a request ends in one status result.
          state_nxt = ST_STAT;
          skind_nxt = KIND_STATUS;
          ovf_nxt   = 1'b0;
          ins_nxt   = 1'b0;
          back_nxt  = 1'b0;
          key_nxt   = c;
          if (in_tuser) begin
            // End of input abandons any escape and flushes or ends.
            ph_nxt  = PH_IDLE;
            dig_nxt = '0;
            if (len_r == '0) begin
              cur_nxt   = '0;
              skind_nxt = KIND_END;
            end else begin
              src_nxt   = '0;
              cnt_nxt   = len_r;
              len_nxt   = '0;
              cur_nxt   = '0;
              state_nxt = ST_SD_RD;
            end
          end else if (ph_r != PH_IDLE) begin
            ph_nxt = PH_IDLE;
            case (ph_r)
              PH_ESC: begin
                if (c == "[") ph_nxt = PH_CSI;
                else if (c == "O") ph_nxt = PH_SS3;
              end
              PH_CSI: begin
                if (c inside {["0":"9"]}) begin
                  dig_nxt = c;
                  ph_nxt  = PH_DIGIT;
                end else if (c == "C") begin
                  if (cur_r < len_r) cur_nxt = cur_r + 1'b1;
                end else if (c == "D") begin
                  if (cur_r != '0) cur_nxt = cur_r - 1'b1;
                end else if (c == "H") begin
                  cur_nxt = '0;
                end else if (c == "F") begin
                  cur_nxt = len_r;
                end
              end
              PH_SS3: begin
                if (c == "H") cur_nxt = '0;
                else if (c == "F") cur_nxt = len_r;
              end
              PH_DIGIT: begin
                dig_nxt = '0;
                if (c == KEY_TILDE) begin
                  if (dig_r == "3") begin
                    if (cur_r < len_r) begin
                      dst_nxt   = cur_r;
                      src_nxt   = cur_r + 1'b1;
                      cnt_nxt   = len_r - cur_r - 1'b1;
                      len_nxt   = len_r - 1'b1;
                      state_nxt = ST_CP_RD;
                    end
                  end else if (dig_r == "1") begin
                    cur_nxt = '0;
                  end else if (dig_r == "4") begin
                    cur_nxt = len_r;
                  end
                end
              end
              default: ph_nxt = PH_IDLE;
            endcase
          end else begin
            case (c)
              KEY_CR, KEY_LF: begin
                if (len_r == '0) begin
                  skind_nxt = KIND_EMPTY;
                end else begin
                  src_nxt   = '0;
                  cnt_nxt   = len_r;
                  len_nxt   = '0;
                  cur_nxt   = '0;
                  state_nxt = ST_SD_RD;
                end
              end
              KEY_CTRL_C: begin
                len_nxt = '0;
                cur_nxt = '0;
              end
              KEY_CTRL_D: begin
                if (len_r == '0) begin
                  cur_nxt   = '0;
                  skind_nxt = KIND_END;
                end else if (cur_r < len_r) begin
                  dst_nxt   = cur_r;
                  src_nxt   = cur_r + 1'b1;
                  cnt_nxt   = len_r - cur_r - 1'b1;
                  len_nxt   = len_r - 1'b1;
                  state_nxt = ST_CP_RD;
                end
              end
              KEY_BS, KEY_DEL: begin
                if (cur_r != '0) begin
                  // Cursor stays inside the line, so a delete always follows.
                  cur_nxt   = cur_r - 1'b1;
                  dst_nxt   = cur_r - 1'b1;
                  src_nxt   = cur_r;
                  cnt_nxt   = len_r - cur_r;
                  len_nxt   = len_r - 1'b1;
                  state_nxt = ST_CP_RD;
                end
              end
              KEY_CTRL_A: cur_nxt = '0;
              KEY_CTRL_E: cur_nxt = len_r;
              KEY_CTRL_K: len_nxt = cur_r;
              KEY_CTRL_U: begin
                if (cur_r != '0) begin
                  dst_nxt   = '0;
                  src_nxt   = cur_r;
                  cnt_nxt   = len_r - cur_r;
                  len_nxt   = len_r - cur_r;
                  cur_nxt   = '0;
                  state_nxt = ST_CP_RD;
                end
              end
              KEY_CTRL_W: begin
                old_nxt   = cur_r;
                src_nxt   = cur_r - 1'b1;
                state_nxt = ST_W1_RD;
              end
              KEY_ESC: ph_nxt = PH_ESC;
              default: begin
                if (c inside {[KEY_SPACE:KEY_TILDE]}) begin
                  if (len_r >= CAP) begin
                    ovf_nxt = 1'b1;
                  end else begin
                    // Open a gap at the cursor by copying from the top down.
                    back_nxt  = 1'b1;
                    ins_nxt   = 1'b1;
                    src_nxt   = len_r - 1'b1;
                    dst_nxt   = len_r;
                    cnt_nxt   = len_r - cur_r;
                    state_nxt = ST_CP_RD;
                  end
                end
              end
            endcase
          end
        end
      end

      ST_CP_RD: begin
        if (cnt_r == '0) begin
          state_nxt = ins_r ? ST_INS : ST_STAT;
        end else begin
          state_nxt = ST_CP_WR;
        end
      end

      ST_CP_WR: begin
        we      = 1'b1;
        cnt_nxt = cnt_r - 1'b1;
        if (back_r) begin
          src_nxt = src_r - 1'b1;
          dst_nxt = dst_r - 1'b1;
        end else begin
          src_nxt = src_r + 1'b1;
          dst_nxt = dst_r + 1'b1;
        end
        state_nxt = ST_CP_RD;
      end

      ST_INS: begin
        we        = 1'b1;
        waddr     = cur_r[ADDR_W-1:0];
        wdata     = key_r;
        cur_nxt   = cur_r + 1'b1;
        len_nxt   = len_r + 1'b1;
        state_nxt = ST_STAT;
      end

      // Word rubout: skip spaces, then the word, before the cursor.
      ST_W1_RD: begin
        if (cur_r == '0) begin
          state_nxt = ST_W2_RD;
        end else begin
          state_nxt = ST_W1_CHK;
        end
      end
      ST_W1_CHK: begin
        if (rdata_r == KEY_SPACE) begin
          cur_nxt   = cur_r - 1'b1;
          src_nxt   = cur_r - 2'd2;
          state_nxt = ST_W1_RD;
        end else begin
          state_nxt = ST_W2_RD;
        end
      end
      ST_W2_RD: begin
        if (cur_r == '0) begin
          dst_nxt   = cur_r;
          src_nxt   = old_r;
          cnt_nxt   = len_r - old_r;
          len_nxt   = len_r - (old_r - cur_r);
          state_nxt = ST_CP_RD;
        end else begin
          state_nxt = ST_W2_CHK;
        end
      end
      ST_W2_CHK: begin
        if (rdata_r != KEY_SPACE) begin
          cur_nxt   = cur_r - 1'b1;
          src_nxt   = cur_r - 2'd2;
          state_nxt = ST_W2_RD;
        end else begin
          dst_nxt   = cur_r;
          src_nxt   = old_r;
          cnt_nxt   = len_r - old_r;
          len_nxt   = len_r - (old_r - cur_r);
          state_nxt = ST_CP_RD;
        end
      end

      ST_SD_RD: state_nxt = ST_SD_LD;

      ST_SD_LD: begin
        if (out_free) begin
          ld        = 1'b1;
          ld_kind   = KIND_BYTE;
          ld_char   = rdata_r;
          ld_ovf    = 1'b0;
          ld_last   = (cnt_r == ptr_t'(1));
          cnt_nxt   = cnt_r - 1'b1;
          src_nxt   = src_r + 1'b1;
          state_nxt = (cnt_r == ptr_t'(1)) ? ST_IDLE : ST_SD_RD;
        end
      end

      ST_STAT: begin
        if (out_free) begin
          ld        = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      cur_r       <= '0;
      ph_r        <= PH_IDLE;
      dig_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      cur_r   <= cur_nxt;
      ph_r    <= ph_nxt;
      dig_r   <= dig_nxt;
      if (ld) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    src_r   <= src_nxt;
    dst_r   <= dst_nxt;
    cnt_r   <= cnt_nxt;
    old_r   <= old_nxt;
    back_r  <= back_nxt;
    ins_r   <= ins_nxt;
    ovf_r   <= ovf_nxt;
    skind_r <= skind_nxt;
    key_r   <= key_nxt;
    if (ld) begin
      o_kind_r <= ld_kind;
      o_char_r <= ld_char;
      o_cur_r  <= cur_r;
      o_len_r  <= len_r;
      o_ovf_r  <= ld_ovf;
      o_last_r <= ld_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, o_ovf_r, o_len_r, o_cur_r, o_char_r};
  assign out_tuser  = o_kind_r;
  assign out_tlast  = o_last_r;

  `TLE_ASSERT_ALWAYS(a_cur_in_line, cur_r <= len_r, "cursor beyond line end")
  `TLE_ASSERT_ALWAYS(a_len_in_cap, len_r <= CAP, "line length beyond capacity")
  `TLE_ASSERT_NEXT(a_byte_after_clear, ld && (ld_kind == KIND_BYTE), (o_cur_r == '0) && (o_len_r == '0), "line byte result without cleared line")
  `TLE_ASSERT_ALWAYS(a_no_write_idle, !(we && (state_r == ST_IDLE)), "memory write while idle")

endmodule
`default_nettype wire

### sim/tb.sv
// ============================================================================
// Terminal line editor testbench
// Drives keystroke requests through a directed table and three random phases,
// predicts results with a behavioural line editor or takes them from the table, and checks each field.
// ============================================================================
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import tle_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int N_RANDOM    = 300;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    logic [6:0] cur;
    logic [6:0] len;
    logic       ovf;
    logic       last;
  } edit_result_t;

  typedef struct {
    logic [7:0] key;
    logic       eoi;
    logic       typed;   // expected status result given in the row
    kind_t      kind;
    logic [6:0] cur;
    logic [6:0] len;
    logic       ovf;
  } key_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  // Idle chances in percent for each side.
  int unsigned send_idle = 31;
  int unsigned recv_idle = 87;
  int          error_count = 0;
  int unsigned cycle_count = 0;

  // Predicted editor state.
  logic [7:0] ed_store [LINE_CAPACITY];
  int         ed_len, ed_cur, ed_digit;
  phase_t     ed_phase;

  edit_result_t pending_results [$];

  always #4 clk = ~clk;

  terminal_line_editor_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
  endtask

  function automatic edit_result_t make_result(kind_t k, logic [7:0] c, logic o, logic l);
    edit_result_t r;
    r.kind = k; r.ch = c; r.cur = ed_cur[6:0]; r.len = ed_len[6:0];
    r.ovf = o; r.last = l;
    return r;
  endfunction

  function automatic void delete_under_cursor();
    if (ed_cur >= ed_len) return;
    for (int i = ed_cur; i < ed_len - 1; i++) ed_store[i] = ed_store[i+1];
    ed_len--;
  endfunction

  // Sends out the line (or the empty-line marker) and clears it.
  function automatic void flush_line();
    int n;
    n = ed_len;
    if (n == 0) begin
      pending_results.push_back(make_result(KIND_EMPTY, 8'd0, 1'b0, 1'b1));
      return;
    end
    ed_len = 0;
    ed_cur = 0;
    for (int i = 0; i < n; i++)
      pending_results.push_back(make_result(KIND_BYTE, ed_store[i], 1'b0, i == n - 1));
  endfunction

  function automatic void continue_escape(logic [7:0] c);
    phase_t ph;
    ph = ed_phase;
    ed_phase = PH_IDLE;
    case (ph)
      PH_ESC: begin
        if (c == "[") ed_phase = PH_CSI;
        else if (c == "O") ed_phase = PH_SS3;
      end
      PH_CSI: begin
        if (c >= "0" && c <= "9") begin
          ed_digit = c;
          ed_phase = PH_DIGIT;
        end else if (c == "C") begin
          if (ed_cur < ed_len) ed_cur++;
        end else if (c == "D") begin
          if (ed_cur > 0) ed_cur--;
        end else if (c == "H") ed_cur = 0;
        else if (c == "F") ed_cur = ed_len;
      end
      PH_SS3: begin
        if (c == "H") ed_cur = 0;
        else if (c == "F") ed_cur = ed_len;
      end
      PH_DIGIT: begin
        if (c == KEY_TILDE) begin
          if (ed_digit == "3") delete_under_cursor();
          else if (ed_digit == "1") ed_cur = 0;
          else if (ed_digit == "4") ed_cur = ed_len;
        end
        ed_digit = 0;
      end
      default: ;
    endcase
  endfunction

  // Applies one keystroke request and queues the results it should cause.
  function automatic void edit_line(logic [7:0] c, logic eoi);
    logic ovf;
    int   old;
    ovf = 1'b0;
    if (eoi) begin
      ed_phase = PH_IDLE;
      ed_digit = 0;
      if (ed_len == 0) begin
        ed_cur = 0;
        pending_results.push_back(make_result(KIND_END, 8'd0, 1'b0, 1'b1));
      end else flush_line();
      return;
    end
    if (ed_phase != PH_IDLE) continue_escape(c);
    else if (c == KEY_CR || c == KEY_LF) begin
      flush_line();
      return;
    end else if (c == KEY_CTRL_C) begin
      ed_len = 0; ed_cur = 0;
    end else if (c == KEY_CTRL_D) begin
      if (ed_len == 0) begin
        ed_cur = 0;
        pending_results.push_back(make_result(KIND_END, 8'd0, 1'b0, 1'b1));
        return;
      end
      delete_under_cursor();
    end else if (c == KEY_BS || c == KEY_DEL) begin
      if (ed_cur > 0) begin
        ed_cur--;
        delete_under_cursor();
      end
    end else if (c == KEY_CTRL_A) ed_cur = 0;
    else if (c == KEY_CTRL_E) ed_cur = ed_len;
    else if (c == KEY_CTRL_K) ed_len = ed_cur;
    else if (c == KEY_CTRL_U) begin
      if (ed_cur > 0) begin
        for (int i = 0; i < ed_len - ed_cur; i++) ed_store[i] = ed_store[i+ed_cur];
        ed_len -= ed_cur;
        ed_cur = 0;
      end
    end else if (c == KEY_CTRL_W) begin
      old = ed_cur;
      while (ed_cur > 0 && ed_store[ed_cur-1] == KEY_SPACE) ed_cur--;
      while (ed_cur > 0 && ed_store[ed_cur-1] != KEY_SPACE) ed_cur--;
      for (int i = 0; i < ed_len - old; i++) ed_store[ed_cur+i] = ed_store[old+i];
      ed_len -= old - ed_cur;
    end else if (c == KEY_ESC) ed_phase = PH_ESC;
    else if (c >= KEY_SPACE && c <= KEY_TILDE) begin
      if (ed_len >= LINE_CAPACITY) ovf = 1'b1;
      else begin
        for (int i = ed_len; i > ed_cur; i--) ed_store[i] = ed_store[i-1];
        ed_store[ed_cur] = c;
        ed_cur++;
        ed_len++;
      end
    end
    pending_results.push_back(make_result(KIND_STATUS, 8'd0, ovf, 1'b1));
  endfunction

  // Result side: random stall, compare each accepted result with the oldest
  // expectation.
  always @(posedge clk) begin
    edit_result_t want;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result kind", out_tuser, -1);
      end else begin
        want = pending_results.pop_front();
        if (out_tuser != want.kind) report_mismatch("kind", out_tuser, want.kind);
        if (out_tdata[7:0] != want.ch) report_mismatch("char", out_tdata[7:0], want.ch);
        if (out_tdata[14:8] != want.cur) report_mismatch("cursor", out_tdata[14:8], want.cur);
        if (out_tdata[21:15] != want.len)
          report_mismatch("length", out_tdata[21:15], want.len);
        if (out_tdata[22] != want.ovf) report_mismatch("overflow", out_tdata[22], want.ovf);
        if (out_tlast != want.last) report_mismatch("last", out_tlast, want.last);
      end
    end
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Sends one keystroke request after an optional random gap, and predicts it.
  // The valid line drops only while the sender idles, so a request that
  // follows straight on keeps it high.
  task automatic send_key(input logic [7:0] c, input logic eoi);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tuser  <= eoi;
    do @(posedge clk); while (!in_tready);
    edit_line(c, eoi);
  endtask

  // Random printable byte, biased towards spaces so that word rubout has
  // words to find.
  function automatic logic [7:0] random_text();
    if ($urandom_range(3) == 0) return KEY_SPACE;
    return 8'($urandom_range(126, 33));
  endfunction

  // Random keystroke, mostly edits and well-formed escape sequences.
  task automatic send_random_key();
    int sel;
    logic [7:0] pick [10];
    pick = '{KEY_CTRL_A, KEY_CTRL_C, KEY_CTRL_D, KEY_CTRL_E, KEY_BS, KEY_CTRL_K,
             KEY_CTRL_U, KEY_CTRL_W, KEY_DEL, KEY_CR};
    sel = $urandom_range(99);
    if (sel < 50) send_key(random_text(), 1'b0);
    else if (sel < 68) send_key(pick[$urandom_range(9)], 1'b0);
    else if (sel < 82) begin
      send_key(KEY_ESC, 1'b0);
      if ($urandom_range(1)) begin
        send_key("[", 1'b0);
        case ($urandom_range(3))
          0: send_key(8'("CDHF" >> (8 * $urandom_range(3))), 1'b0);
          1: begin
            send_key(8'("1345" >> (8 * $urandom_range(3))), 1'b0);
            send_key(KEY_TILDE, 1'b0);
          end
          2: send_key("A", 1'b0);
          default: send_key(8'($urandom), 1'b0);
        endcase
      end else begin
        send_key("O", 1'b0);
        send_key($urandom_range(1) ? "H" : "F", 1'b0);
      end
    end else if (sel < 88) send_key(8'($urandom_range(31)), 1'b0);
    else if (sel < 94) send_key(8'($urandom_range(255, 128)), 1'b0);
    else if (sel < 97) send_key(8'($urandom), 1'b0);
    else send_key(8'($urandom), 1'b1);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Directed rows; rows marked typed have their status result written in,
  // the rest rely on the predictor.
  key_row_t key_table [$] = '{
    '{8'hFF, 1'b0, 1'b1, KIND_STATUS, 7'd0, 7'd0, 1'b0},  // high byte ignored
    '{KEY_BS, 1'b0, 1'b1, KIND_STATUS, 7'd0, 7'd0, 1'b0}, // backspace at start
    '{KEY_CTRL_U, 1'b0, 1'b1, KIND_STATUS, 7'd0, 7'd0, 1'b0},
    '{8'd9, 1'b0, 1'b1, KIND_STATUS, 7'd0, 7'd0, 1'b0},   // tab ignored
    '{KEY_CR, 1'b0, 1'b1, KIND_EMPTY, 7'd0, 7'd0, 1'b0},
    '{KEY_SPACE, 1'b0, 1'b1, KIND_STATUS, 7'd1, 7'd1, 1'b0},
    '{KEY_TILDE, 1'b0, 1'b1, KIND_STATUS, 7'd2, 7'd2, 1'b0},
    '{"a", 1'b0, 1'b0, KIND_STATUS, 7'd0, 7'd0, 1'b0},
    '{KEY_ESC, 1'b0, 1'b0, KIND_STATUS, 7'd0, 7'd0, 1'b0},
    '{"[", 1'b0, 1'b0, KIND_STATUS, 7'd0, 7'd0, 1'b0},
    '{"D", 1'b0, 1'b0, KIND_STATUS, 7'd0, 7'd0, 1'b0},
    '{KEY_ESC, 1'b0, 1'b0, KIND_STATUS, 7'd0, 7'd0, 1'b0},
    '{"[", 1'b0, 1'b0, KIND_STATUS, 7'd0, 7'd0, 1'b0},
    '{"3", 1'b0, 1'b0, KIND_STATUS, 7'd0, 7'd0, 1'b0},
    '{KEY_TILDE, 1'b0, 1'b0, KIND_STATUS, 7'd0, 7'd0, 1'b0},
    '{KEY_CTRL_A, 1'b0, 1'b0, KIND_STATUS, 7'd0, 7'd0, 1'b0},
    '{KEY_CTRL_D, 1'b0, 1'b0, KIND_STATUS, 7'd0, 7'd0, 1'b0},
    '{KEY_CTRL_W, 1'b0, 1'b0, KIND_STATUS, 7'd0, 7'd0, 1'b0},
    '{KEY_CTRL_E, 1'b0, 1'b0, KIND_STATUS, 7'd0, 7'd0, 1'b0},
    '{KEY_CTRL_K, 1'b0, 1'b0, KIND_STATUS, 7'd0, 7'd0, 1'b0},
    '{KEY_ESC, 1'b0, 1'b0, KIND_STATUS, 7'd0, 7'd0, 1'b0},
    '{"O", 1'b0, 1'b0, KIND_STATUS, 7'd0, 7'd0, 1'b0},
    '{8'hA5, 1'b1, 1'b0, KIND_STATUS, 7'd0, 7'd0, 1'b0},  // end with a line
    '{8'h5A, 1'b1, 1'b1, KIND_END, 7'd0, 7'd0, 1'b0},
    '{KEY_CTRL_D, 1'b0, 1'b1, KIND_END, 7'd0, 7'd0, 1'b0}
  };

  initial begin
    for (int i = 0; i < LINE_CAPACITY; i++) ed_store[i] = '0;
    ed_len = 0; ed_cur = 0; ed_digit = 0; ed_phase = PH_IDLE;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (key_table[i]) begin
      if (key_table[i].typed) begin
        send_key(key_table[i].key, key_table[i].eoi);
        // Overwrite the predicted expectation with the one written in the row.
        pending_results[$] = '{key_table[i].kind, 8'd0, key_table[i].cur,
                               key_table[i].len, key_table[i].ovf, 1'b1};
      end else send_key(key_table[i].key, key_table[i].eoi);
    end

    // Fill the line to capacity and beyond, then send it out at full width.
    for (int i = 0; i < LINE_CAPACITY + 2; i++) send_key(random_text(), 1'b0);
    wait_drained();  // hold off until every expected result has come
    send_key(KEY_CR, 1'b0);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 31 : (phase == 1) ? 87 : 0;
      recv_idle = (phase == 0) ? 87 : (phase == 1) ? 31 : 0;
      for (int n = 0; n < N_RANDOM / 3; n++) send_random_key();
    end

    wait_drained();
    repeat (200) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire

### terminal_line_editor_unit.f
+incdir+hdl
hdl/tle_pkg.sv
hdl/terminal_line_editor_unit.sv
sim/tb.sv
